// File: sv/tcc_pkg.sv
// tcc_pkg: shared types and fixed constants of the timecourse cosine correlation core.
// Depends on nothing; used by tcc_fifo, tcc_back and the top-level core.
`default_nettype none

package tcc_pkg;

    localparam int CORR_W    = 16;              // Q1.15 result width
    localparam int FRAC_BITS = 15;              // fraction bits of the result
    localparam int Q_BITS    = FRAC_BITS + 1;   // magnitude bits found by the search
    localparam int K_W       = $clog2(Q_BITS);  // index of one magnitude bit

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic signed [CORR_W-1:0] correlation;
        logic                     zero_norm;
    } t_result;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_ADD  = 5'b00100,
        ST_CMP  = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;

endpackage

`default_nettype wire

// File: sv/tcc_fifo.sv
// tcc_fifo: two-entry queue used between front and back end and on the result side.
// Depends on tcc_pkg for the status struct.
`default_nettype none

module tcc_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire logic [WIDTH-1:0]      i_data,
    input  wire logic                  i_pop,
    output logic      [WIDTH-1:0]      o_data,
    output tcc_pkg::t_q_status         o_status
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic [1:0]       n_count;
    logic             w_push;
    logic             w_pop;

    assign w_push = i_push && (r_count != 2'd2);
    assign w_pop  = i_pop && (r_count != 2'd0);

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);

endmodule

`default_nettype wire

// File: sv/tcc_front.sv
// tcc_front: per-frame accumulation of dot product and both energies, with saturation.
// Hands a finished (dot, seed energy, vertex energy) job out on the last frame.
`default_nettype none

module tcc_front #(
    parameter int SAMPLE_BITS = 16,
    parameter int E_W         = 41,
    parameter int D_W         = 42
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic signed [SAMPLE_BITS-1:0] i_seed_sample,
    input  wire logic signed [SAMPLE_BITS-1:0] i_vertex_sample,
    input  wire logic                          i_last_frame,
    output logic                               o_job_push,
    output logic [D_W+2*E_W-1:0]               o_job
);

    localparam int PR_W = 2 * SAMPLE_BITS;

    logic signed [D_W-1:0]  r_dot;
    logic        [E_W-1:0]  r_seed_e;
    logic        [E_W-1:0]  r_vert_e;

    logic signed [PR_W-1:0] w_prod;
    logic signed [PR_W-1:0] w_sq_seed;
    logic signed [PR_W-1:0] w_sq_vert;
    logic signed [D_W:0]    w_dot_wide;
    logic        [E_W:0]    w_seed_wide;
    logic        [E_W:0]    w_vert_wide;
    logic signed [D_W-1:0]  n_dot;
    logic        [E_W-1:0]  n_seed_e;
    logic        [E_W-1:0]  n_vert_e;

    assign w_prod    = i_seed_sample * i_vertex_sample;
    assign w_sq_seed = i_seed_sample * i_seed_sample;
    assign w_sq_vert = i_vertex_sample * i_vertex_sample;

    always_comb begin
        w_dot_wide  = (D_W+1)'(r_dot) + (D_W+1)'(w_prod);
        w_seed_wide = {1'b0, r_seed_e} + (E_W+1)'(w_sq_seed[PR_W-2:0]);
        w_vert_wide = {1'b0, r_vert_e} + (E_W+1)'(w_sq_vert[PR_W-2:0]);

        // clamp dot on overflow of its width
        if (w_dot_wide[D_W] != w_dot_wide[D_W-1]) begin
            n_dot = w_dot_wide[D_W] ? {1'b1, {(D_W-1){1'b0}}} : {1'b0, {(D_W-1){1'b1}}};
        end else begin
            n_dot = w_dot_wide[D_W-1:0];
        end
        n_seed_e = w_seed_wide[E_W] ? {E_W{1'b1}} : w_seed_wide[E_W-1:0];
        n_vert_e = w_vert_wide[E_W] ? {E_W{1'b1}} : w_vert_wide[E_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot    <= '0;
            r_seed_e <= '0;
            r_vert_e <= '0;
        end else if (i_accept) begin
            if (i_last_frame) begin
                r_dot    <= '0;
                r_seed_e <= '0;
                r_vert_e <= '0;
            end else begin
                r_dot    <= n_dot;
                r_seed_e <= n_seed_e;
                r_vert_e <= n_vert_e;
            end
        end
    end

    assign o_job_push = i_accept && i_last_frame;
    assign o_job      = {n_dot, n_seed_e, n_vert_e};

endmodule

`default_nettype wire

// File: sv/tcc_back.sv
// tcc_back: sequential back end; shift-add products, then a bit-by-bit search for
// the largest q with q^2 * e1 * e2 <= 2^30 * dot^2. Depends on tcc_pkg.
`default_nettype none

module tcc_back #(
    parameter int E_W = 41,
    parameter int D_W = 42
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_job_valid,
    input  wire logic [D_W+2*E_W-1:0]   i_job,
    output logic                        o_job_pop,
    input  wire logic                   i_res_full,
    output logic                        o_res_push,
    output tcc_pkg::t_result            o_result
);

    localparam int M_W   = D_W;
    localparam int P_W   = 2 * E_W;
    localparam int DSQ_W = 2 * M_W;
    localparam int SH    = 2 * tcc_pkg::FRAC_BITS;
    localparam int W     = DSQ_W + SH + 2;
    localparam int CNT_W = $clog2(M_W + 1);
    localparam int QB    = tcc_pkg::Q_BITS;
    localparam int KW    = tcc_pkg::K_W;

    tcc_pkg::t_state r_state, n_state;

    logic              r_neg, n_neg;
    logic              r_zero, n_zero;
    logic [DSQ_W-1:0]  r_mag_a, n_mag_a;
    logic [M_W-1:0]    r_mag_b, n_mag_b;
    logic [DSQ_W-1:0]  r_dsq, n_dsq;
    logic [P_W-1:0]    r_e_a, n_e_a;
    logic [E_W-1:0]    r_e_b, n_e_b;
    logic [P_W-1:0]    r_p, n_p;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [W-1:0]      r_s, n_s;
    logic [W-1:0]      r_a, n_a;
    logic [W-1:0]      r_b, n_b;
    logic [W-1:0]      r_t, n_t;
    logic [KW-1:0]     r_k, n_k;
    logic [QB-1:0]     r_q, n_q;

    logic signed [D_W-1:0] w_dot;
    logic [E_W-1:0]        w_e1;
    logic [E_W-1:0]        w_e2;
    logic [M_W-1:0]        w_mag;
    logic [W-1:0]          w_rhs;
    logic [W-1:0]          w_trial;
    logic [W-1:0]          w_a_acc;

    assign w_dot   = i_job[D_W+2*E_W-1 -: D_W];
    assign w_e1    = i_job[2*E_W-1 -: E_W];
    assign w_e2    = i_job[E_W-1:0];
    assign w_mag   = w_dot[D_W-1] ? (~w_dot + 1'b1) : w_dot;
    assign w_rhs   = W'(r_dsq) << SH;
    assign w_trial = r_t + r_b;
    assign w_a_acc = r_a + (r_b << 1);

    always_comb begin
        n_state  = r_state;
        n_neg    = r_neg;
        n_zero   = r_zero;
        n_mag_a  = r_mag_a;
        n_mag_b  = r_mag_b;
        n_dsq    = r_dsq;
        n_e_a    = r_e_a;
        n_e_b    = r_e_b;
        n_p      = r_p;
        n_cnt    = r_cnt;
        n_s      = r_s;
        n_a      = r_a;
        n_b      = r_b;
        n_t      = r_t;
        n_k      = r_k;
        n_q      = r_q;
        o_job_pop  = 1'b0;
        o_res_push = 1'b0;
        case (r_state)
            tcc_pkg::ST_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_neg   = w_dot[D_W-1];
                    n_zero  = (w_e1 == '0) || (w_e2 == '0);
                    n_mag_a = DSQ_W'(w_mag);
                    n_mag_b = w_mag;
                    n_e_a   = P_W'(w_e1);
                    n_e_b   = w_e2;
                    n_dsq   = '0;
                    n_p     = '0;
                    n_cnt   = '0;
                    n_q     = '0;
                    n_state = n_zero ? tcc_pkg::ST_DONE : tcc_pkg::ST_MUL;
                end
            end
            tcc_pkg::ST_MUL: begin
                if (r_mag_b[0]) begin
                    n_dsq = r_dsq + r_mag_a;
                end
                if (r_e_b[0]) begin
                    n_p = r_p + r_e_a;
                end
                n_mag_a = r_mag_a << 1;
                n_mag_b = r_mag_b >> 1;
                n_e_a   = r_e_a << 1;
                n_e_b   = r_e_b >> 1;
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(M_W - 1)) begin
                    // search setup: S = 0, A = q*P << (k+1) = 0, B = P << 2k
                    n_s     = '0;
                    n_a     = '0;
                    n_b     = W'(n_p) << (2 * (QB - 1));
                    n_k     = KW'(QB - 1);
                    n_state = tcc_pkg::ST_ADD;
                end
            end
            tcc_pkg::ST_ADD: begin
                n_t     = r_s + r_a;
                n_state = tcc_pkg::ST_CMP;
            end
            tcc_pkg::ST_CMP: begin
                // trial (q | 2^k)^2 * P = S + A + B
                if (w_trial <= w_rhs) begin
                    n_s      = w_trial;
                    n_a      = w_a_acc >> 1;
                    n_q[r_k] = 1'b1;
                end else begin
                    n_a = r_a >> 1;
                end
                n_b = r_b >> 2;
                if (r_k == '0) begin
                    n_state = tcc_pkg::ST_DONE;
                end else begin
                    n_k     = r_k - 1'b1;
                    n_state = tcc_pkg::ST_ADD;
                end
            end
            tcc_pkg::ST_DONE: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = tcc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tcc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg   <= n_neg;
        r_zero  <= n_zero;
        r_mag_a <= n_mag_a;
        r_mag_b <= n_mag_b;
        r_dsq   <= n_dsq;
        r_e_a   <= n_e_a;
        r_e_b   <= n_e_b;
        r_p     <= n_p;
        r_cnt   <= n_cnt;
        r_s     <= n_s;
        r_a     <= n_a;
        r_b     <= n_b;
        r_t     <= n_t;
        r_k     <= n_k;
        r_q     <= n_q;
    end

    // top magnitude bit set means q >= 1.0: clamp to 32767, or to -32768 when negative
    always_comb begin
        o_result.zero_norm = r_zero;
        if (r_zero) begin
            o_result.correlation = '0;
        end else if (r_neg) begin
            o_result.correlation = r_q[QB-1] ? {1'b1, {(QB-1){1'b0}}} : (~r_q + 1'b1);
        end else begin
            o_result.correlation = r_q[QB-1] ? {1'b0, {(QB-1){1'b1}}} : r_q;
        end
    end

endmodule

`default_nettype wire

// File: sv/timecourse_cosine_correlation_core.sv
// Timecourse cosine correlation core: streams sample pairs, emits dot/(|s|*|v|) in Q1.15.
// Throughput: one sample-pair transaction per cycle while the job queue has room.
// The back end works on one job at a time and takes the next job only after the
// result of the last one has gone into the result queue.
// Reset: synchronous, active low; clears accumulators, queues and the back-end sequencer.
// Depends on tcc_pkg, tcc_front, tcc_fifo and tcc_back.
`default_nettype none

module timecourse_cosine_correlation_core #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_FRAMES  = 1024
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 push,
    output logic                                      full,
    input  wire logic signed [SAMPLE_BITS-1:0]        i_seed_sample,
    input  wire logic signed [SAMPLE_BITS-1:0]        i_vertex_sample,
    input  wire logic                                 i_last_frame,
    output logic                                      empty,
    input  wire logic                                 pop,
    output logic signed [tcc_pkg::CORR_W-1:0]         o_correlation,
    output logic                                      o_zero_norm
);

    // Energy width holds MAX_FRAMES full-scale squares; dot carries one more bit for sign.
    localparam int E_W   = 2 * SAMPLE_BITS - 1 + $clog2(MAX_FRAMES);
    localparam int D_W   = E_W + 1;
    localparam int JOB_W = D_W + 2 * E_W;
    localparam int RES_W = $bits(tcc_pkg::t_result);

    logic                 w_accept;
    logic                 w_job_push;
    logic [JOB_W-1:0]     w_job_in;
    logic [JOB_W-1:0]     w_job_out;
    logic                 w_job_pop;
    tcc_pkg::t_q_status   w_job_status;
    logic                 w_res_push;
    tcc_pkg::t_result     w_res_in;
    tcc_pkg::t_result     w_res_out;
    tcc_pkg::t_q_status   w_res_status;

    // A transaction is refused whenever the job queue is full, last frame or not.
    assign full     = w_job_status.full;
    assign w_accept = push && !w_job_status.full;

    // Front end: one accumulate per accepted transaction.
    tcc_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .E_W         (E_W),
        .D_W         (D_W)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_seed_sample   (i_seed_sample),
        .i_vertex_sample (i_vertex_sample),
        .i_last_frame    (i_last_frame),
        .o_job_push      (w_job_push),
        .o_job           (w_job_in)
    );

    // Short job queue decouples the stream from the long back-end computation.
    tcc_fifo #(
        .WIDTH (JOB_W)
    ) u_job_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_job_push),
        .i_data   (w_job_in),
        .i_pop    (w_job_pop),
        .o_data   (w_job_out),
        .o_status (w_job_status)
    );

    // Back end: products by shift-add, then magnitude bit search.
    tcc_back #(
        .E_W (E_W),
        .D_W (D_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!w_job_status.empty),
        .i_job       (w_job_out),
        .o_job_pop   (w_job_pop),
        .i_res_full  (w_res_status.full),
        .o_res_push  (w_res_push),
        .o_result    (w_res_in)
    );

    // Result queue: a finished result waits here while the back end takes the next job.
    tcc_fifo #(
        .WIDTH (RES_W)
    ) u_res_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_res_push),
        .i_data   (w_res_in),
        .i_pop    (pop),
        .o_data   (w_res_out),
        .o_status (w_res_status)
    );

    assign empty         = w_res_status.empty;
    assign o_correlation = w_res_out.correlation;
    assign o_zero_norm   = w_res_out.zero_norm;

`ifndef SYNTHESIS
    // Back end only pulls a job that is there.
    a_job_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_job_pop |-> !w_job_status.empty)
        else $error("job popped from empty queue");

    // Back end only delivers a result when the result queue has room.
    a_res_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> !w_res_status.full)
        else $error("result pushed into full queue");

    // A zero-energy result always reads as correlation zero.
    a_zero_norm_corr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_zero_norm) |-> (o_correlation == '0))
        else $error("zero_norm result with nonzero correlation");

    // Front end never offers a job that the queue cannot take.
    a_job_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_job_push |-> !w_job_status.full)
        else $error("job pushed into full queue");
`endif

endmodule

`default_nettype wire

// File: bench/timecourse_cosine_correlation_core_tb.sv
// Self-checking bench for timecourse_cosine_correlation_core: streams sample pairs, predicts
// each Q1.15 cosine result in-bench and checks every popped result against it.
// Depends on tcc_pkg (result type and widths) and the core RTL; nothing else.

module timecourse_cosine_correlation_core_tb;

    localparam int SAMPLE_W   = 16;
    localparam int FRAME_CAP  = 1024;                 // MAX_FRAMES of the instance

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;

    // Accumulator limits: dot is a 42-bit signed sum, energies 41-bit unsigned sums.
    localparam longint          DOT_HI     = (64'sd1 <<< 41) - 64'sd1;
    localparam longint          DOT_LO     = -DOT_HI - 64'sd1;
    localparam longint unsigned ENERGY_TOP = (64'd1 << 41) - 64'd1;

    localparam int Q15_ONE     = 32768;
    localparam int Q15_POS_MAX = 32767;

    // Long full-scale sequences: sums grow well past 32 bits within the frame budget.
    localparam int LONG_FRAMES    = FRAME_CAP / 4;
    localparam int RANDOM_FRAMES  = 700;
    localparam int TAIL_CYCLES    = 200;   // well past the back-end latency
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction on either side

    typedef enum logic [1:0] {
        RX_STREAM,
        RX_RANDOM,
        RX_LONG_STALL
    } t_rx_mode;

    // Shapes of a random sequence: how the vertex samples relate to the seed samples.
    typedef enum int unsigned {
        REL_INDEPENDENT,
        REL_EQUAL,
        REL_NEGATED,
        REL_SCALED,
        REL_NOISY,
        REL_SILENT
    } t_relation;

    // Amplitude styles for a sample.
    typedef enum int unsigned {
        AMP_FULL,
        AMP_SMALL,
        AMP_EXTREME,
        AMP_ZERO
    } t_amplitude;

    // ------------------------------------------------------------------
    // DUT signals: every input starts at a known value
    // ------------------------------------------------------------------
    logic                              i_clk           = 1'b0;
    logic                              i_rst_n         = 1'b0;
    logic                              push            = 1'b0;
    logic                              full;
    logic signed [SAMPLE_W-1:0]        i_seed_sample   = '0;
    logic signed [SAMPLE_W-1:0]        i_vertex_sample = '0;
    logic                              i_last_frame    = 1'b0;
    logic                              empty;
    logic                              pop             = 1'b0;
    logic signed [tcc_pkg::CORR_W-1:0] o_correlation;
    logic                              o_zero_norm;

    timecourse_cosine_correlation_core #(
        .SAMPLE_BITS (SAMPLE_W),
        .MAX_FRAMES  (FRAME_CAP)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_seed_sample   (i_seed_sample),
        .i_vertex_sample (i_vertex_sample),
        .i_last_frame    (i_last_frame),
        .empty           (empty),
        .pop             (pop),
        .o_correlation   (o_correlation),
        .o_zero_norm     (o_zero_norm)
    );

    // 2-unit period; inputs move on the falling edge, everything is sampled on the rising edge.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the three accumulators
    // ------------------------------------------------------------------
    longint          dot_acc   = 0;
    longint unsigned seed_en   = 0;
    longint unsigned vertex_en = 0;

    tcc_pkg::t_result pending_correlations[$];   // expected results, oldest first

    int unsigned frames_sent     = 0;
    int unsigned results_checked = 0;
    int unsigned zero_norm_seen  = 0;
    int unsigned full_scale_seen = 0;
    int unsigned mismatches      = 0;
    int unsigned burst_left      = 0;   // sender pacing

    // Largest q in [0, 1.0] (Q15) with q^2 * e1 * e2 <= 2^30 * mag^2, i.e. the
    // truncated magnitude of mag / sqrt(e1 * e2). 128 bits hold both sides exactly.
    function automatic int unsigned cosine_q15_magnitude(input longint unsigned mag,
                                                         input longint unsigned e1,
                                                         input longint unsigned e2);
        logic [127:0] rhs;
        logic [127:0] lhs;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        rhs = (128'(mag) * 128'(mag)) << 30;
        lo  = 0;
        hi  = Q15_ONE;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            lhs = 128'(mid) * 128'(mid) * 128'(e1) * 128'(e2);
            if (lhs <= rhs) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return lo;
    endfunction

    // Fold one accepted frame into the accumulators; on the last frame queue the
    // expected correlation and clear.
    function automatic void accumulate_frame(input logic signed [SAMPLE_W-1:0] s,
                                             input logic signed [SAMPLE_W-1:0] v,
                                             input logic                       last);
        longint           a;
        longint           b;
        longint unsigned  mag;
        int               corr;
        int unsigned      q;
        tcc_pkg::t_result r;
        a = s;
        b = v;
        dot_acc = dot_acc + a * b;
        if (dot_acc > DOT_HI) begin
            dot_acc = DOT_HI;
        end
        if (dot_acc < DOT_LO) begin
            dot_acc = DOT_LO;
        end
        seed_en = seed_en + longint'(a * a);
        if (seed_en > ENERGY_TOP) begin
            seed_en = ENERGY_TOP;
        end
        vertex_en = vertex_en + longint'(b * b);
        if (vertex_en > ENERGY_TOP) begin
            vertex_en = ENERGY_TOP;
        end
        if (!last) begin
            return;
        end
        if (seed_en == 0 || vertex_en == 0) begin
            r.correlation = '0;
            r.zero_norm   = 1'b1;
        end else begin
            mag  = (dot_acc < 0) ? longint'(-dot_acc) : longint'(dot_acc);
            q    = cosine_q15_magnitude(mag, seed_en, vertex_en);
            corr = (dot_acc < 0) ? -int'(q) : ((q > Q15_POS_MAX) ? Q15_POS_MAX : int'(q));
            r.correlation = corr[tcc_pkg::CORR_W-1:0];
            r.zero_norm   = 1'b0;
        end
        pending_correlations.push_back(r);
        dot_acc   = 0;
        seed_en   = 0;
        vertex_en = 0;
    endfunction

    // ------------------------------------------------------------------
    // Sender: one frame transaction, paced in bursts with random gaps
    // ------------------------------------------------------------------
    task automatic send_frame(input logic signed [SAMPLE_W-1:0] s,
                              input logic signed [SAMPLE_W-1:0] v,
                              input logic                       last);
        int unsigned gap;
        if (burst_left == 0) begin
            // a quarter of bursts follow on with no gap at all
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap) begin
                @(negedge i_clk);
                push <= 1'b0;
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge i_clk);
        push            <= 1'b1;
        i_seed_sample   <= s;
        i_vertex_sample <= v;
        i_last_frame    <= last;
        // hold until the core takes it; full is sampled as it stood before the edge
        do @(posedge i_clk); while (full);
        accumulate_frame(s, v, last);
        frames_sent++;
    endtask

    // Stop sending until every queued result has been popped and checked.
    task automatic wait_all_results();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_correlations.size() != 0) begin
            @(negedge i_clk);
        end
        burst_left = 0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input t_amplitude style);
        logic signed [SAMPLE_W-1:0] x;
        case (style)
            AMP_SMALL: x = SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
            AMP_EXTREME: begin
                case ($urandom_range(0, 4))
                    0:       x = SAMPLE_MIN;
                    1:       x = SAMPLE_MAX;
                    2:       x = -16'sd1;
                    3:       x = 16'sd1;
                    default: x = '0;
                endcase
            end
            AMP_ZERO: x = '0;
            default:  x = SAMPLE_W'($urandom);
        endcase
        return x;
    endfunction

    // ------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------

    // Rails, +-1 and a two-frame pair: +1 saturates to 32767, -1 reaches -32768.
    task automatic test_full_scale();
        send_frame(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
        send_frame(SAMPLE_MIN, SAMPLE_MIN, 1'b1);
        send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
        send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
        send_frame(16'sd1, 16'sd1, 1'b1);
        send_frame(-16'sd1, 16'sd1, 1'b1);
        // 1/sqrt(2): exercises the truncation of an irrational magnitude
        send_frame(16'sd1, 16'sd1, 1'b0);
        send_frame(16'sd1, 16'sd0, 1'b1);
    endtask

    // Either timecourse without energy: correlation forced to 0 with the flag set.
    task automatic test_zero_energy();
        send_frame(16'sd0, 16'sd0, 1'b1);
        send_frame(16'sd0, SAMPLE_MIN, 1'b1);
        send_frame(SAMPLE_MAX, 16'sd0, 1'b1);
        send_frame(16'sd0, 16'sd5, 1'b0);
        send_frame(16'sd0, -16'sd3, 1'b1);
    endtask

    // Multi-frame pairs: non-final frames must yield nothing; orthogonal pair gives 0.
    task automatic test_short_sequences();
        send_frame(16'sd3, 16'sd4, 1'b0);
        send_frame(16'sd4, -16'sd3, 1'b1);
        send_frame(16'sd1200, -16'sd700, 1'b0);
        send_frame(-16'sd9000, 16'sd250, 1'b0);
        send_frame(16'sd31, 16'sd31000, 1'b0);
        send_frame(SAMPLE_MIN, 16'sd2, 1'b1);
        send_frame(16'sd100, 16'sd99, 1'b0);
        send_frame(16'sd200, 16'sd201, 1'b0);
        send_frame(-16'sd300, -16'sd299, 1'b1);
    endtask

    // Long full-scale sequences: wide sums must carry through the whole back end.
    task automatic test_long_sequences();
        for (int i = 0; i < LONG_FRAMES; i++) begin
            send_frame(SAMPLE_MIN, SAMPLE_MIN, i == LONG_FRAMES - 1);
        end
        for (int i = 0; i < LONG_FRAMES; i++) begin
            send_frame(SAMPLE_MIN, SAMPLE_MAX, i == LONG_FRAMES - 1);
        end
    endtask

    // Random sequences, mostly short so results come often; one full drain midway.
    task automatic test_random_sequences(input int unsigned frame_goal);
        int unsigned                len;
        int unsigned                start;
        t_amplitude                 amp;
        t_relation                  rel;
        logic signed [SAMPLE_W-1:0] s;
        logic signed [SAMPLE_W-1:0] v;
        bit                         drained;
        start   = frames_sent;
        drained = 1'b0;
        while (frames_sent - start < frame_goal) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 80) : $urandom_range(1, 8);
            amp = ($urandom_range(0, 15) == 0) ? AMP_ZERO : t_amplitude'($urandom_range(0, 2));
            rel = t_relation'($urandom_range(0, 5));
            for (int i = 0; i < len; i++) begin
                s = pick_sample(amp);
                case (rel)
                    REL_EQUAL:   v = s;
                    REL_NEGATED: v = -s;
                    REL_SCALED:  v = s >>> $urandom_range(0, 4);
                    REL_NOISY:   v = SAMPLE_W'(int'(s) + int'($urandom_range(0, 64)) - 32);
                    // mostly silent vertex, so zero energy turns up now and then
                    REL_SILENT:  v = ($urandom_range(0, 7) == 0) ? pick_sample(AMP_SMALL) : '0;
                    default:     v = pick_sample(t_amplitude'($urandom_range(0, 2)));
                endcase
                send_frame(s, v, i == len - 1);
            end
            if (!drained && frames_sent - start >= frame_goal / 2) begin
                wait_all_results();
                drained = 1'b1;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: pop mode is redrawn at random each time the phase counter has run through its cycles
    // ------------------------------------------------------------------
    t_rx_mode    rx_mode  = RX_STREAM;
    int unsigned rx_phase = 0;
    int unsigned rx_hold  = 0;

    always @(negedge i_clk) begin
        if (rx_phase == 0) begin
            rx_mode  = t_rx_mode'($urandom_range(0, 2));
            rx_phase = $urandom_range(64, 400);
        end
        rx_phase--;
        if (rx_hold > 0) begin
            rx_hold--;
            pop <= 1'b0;
        end else begin
            case (rx_mode)
                RX_STREAM: pop <= 1'b1;
                RX_RANDOM: pop <= ($urandom_range(0, 3) != 0);
                default: begin
                    if ($urandom_range(0, 7) == 0) begin
                        rx_hold = $urandom_range(5, 24);
                        pop <= 1'b0;
                    end else begin
                        pop <= 1'b1;
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result check: every popped transaction against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        tcc_pkg::t_result want;
        if (i_rst_n && pop && !empty) begin
            if (pending_correlations.size() == 0) begin
                $error("correlation result %0d with none expected", o_correlation);
                mismatches++;
            end else begin
                want = pending_correlations.pop_front();
                if (o_correlation !== want.correlation) begin
                    $error("correlation: expected %0d, got %0d",
                           want.correlation, o_correlation);
                    mismatches++;
                end
                if (o_zero_norm !== want.zero_norm) begin
                    $error("zero_norm: expected %0b, got %0b", want.zero_norm, o_zero_norm);
                    mismatches++;
                end
                results_checked++;
                if (want.zero_norm) begin
                    zero_norm_seen++;
                end
                if (want.correlation == SAMPLE_MAX || want.correlation == SAMPLE_MIN) begin
                    full_scale_seen++;
                end
            end
        end
    end

    // Watchdog: a run that stops moving is a failure.
    int unsigned idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------
    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_full_scale();
        test_zero_energy();
        test_short_sequences();
        test_long_sequences();
        test_random_sequences(RANDOM_FRAMES);

        wait_all_results();
        // anything popped from here on has no expectation and is flagged by the checker
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Streamed %0d frame transactions; checked %0d correlation results",
                 frames_sent, results_checked);
        $display("(%0d with zero energy, %0d at Q1.15 full scale, incl. long sequences).",
                 zero_norm_seen, full_scale_seen);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
